// ----- rtl/core/cpst_pkg.sv -----
// ----------------------------------------------------------------------------
// cpst_pkg
// Shared types, status codes and constants for the complex pair set table.
// ----------------------------------------------------------------------------
package cpst_pkg;

   // default number of table entries
   localparam int unsigned DEPTH_DEFAULT = 16;

   // configuration port
   localparam int unsigned CSR_AW        = 3;
   localparam int unsigned CSR_DW        = 32;
   localparam logic [4:0]  CAP_RESET     = 5'd16;

   // result status codes
   localparam logic [2:0] ST_ADDED   = 3'd0;
   localparam logic [2:0] ST_PRESENT = 3'd1;
   localparam logic [2:0] ST_REMOVED = 3'd2;
   localparam logic [2:0] ST_MISSING = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;
   localparam logic [2:0] ST_EMPTY   = 3'd5;

   // operation codes
   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // input beat
   typedef struct packed {
      logic               opcode;
      logic signed [31:0] real_part;
      logic signed [31:0] imag_part;
   } req_type;

   // result beat
   typedef struct packed {
      logic [2:0] status;
      logic [4:0] entry_count;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic       load;
      logic       search;
      logic       rd_last;
      logic       move;
      logic       append;
      logic       rsp_load;
      logic [2:0] rsp_status;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic found;
      logic done;
      logic is_remove;
      logic empty;
      logic full;
   } stat_type;

endpackage

// ----- rtl/core/cpst_ctrl.sv -----
// ----------------------------------------------------------------------------
// cpst_ctrl
// Sequencer for search, append, swap-remove and result hand-off.
// ----------------------------------------------------------------------------
module cpst_ctrl
   import cpst_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_RDLAST = 3'd2;
   localparam logic [2:0] S_MOVE   = 3'd3;
   localparam logic [2:0] S_RESP   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [2:0] status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      cmd            = '0;
      cmd.rsp_status = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            if (stat.found) begin
               if (stat.is_remove) begin
                  state_in = S_RDLAST;
               end else begin
                  status_in = ST_PRESENT;
                  state_in  = S_RESP;
               end
            end else if (stat.done) begin
               state_in = S_RESP;
               if (!stat.is_remove) begin
                  if (stat.full) begin
                     status_in = ST_FULL;
                  end else begin
                     cmd.append = 1'b1;
                     status_in  = ST_ADDED;
                  end
               end else if (stat.empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  status_in = ST_MISSING;
               end
            end
         end
         S_RDLAST: begin
            cmd.rd_last = 1'b1;
            state_in    = S_MOVE;
         end
         S_MOVE: begin
            cmd.move  = 1'b1;
            status_in = ST_REMOVED;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output beat valid
   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

endmodule

// ----- rtl/core/cpst_dp.sv -----
// ----------------------------------------------------------------------------
// cpst_dp
// Entry memory, search pointer, key compare, entry count and result register.
// ----------------------------------------------------------------------------
module cpst_dp
   import cpst_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = DEPTH_DEFAULT
)
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_payload,
   input  logic [4:0] cap,
   input  cmd_type    cmd,
   output stat_type   stat,
   output rsp_type    rsp_payload
);

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned LW = (CW > 5) ? CW : 5;

   logic [63:0]   mem [TABLE_DEPTH];
   logic [63:0]   key_ff;
   logic          op_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic [AW-1:0] cmp_idx_ff;
   logic [AW-1:0] slot_ff;
   logic [63:0]   rdata_ff;
   rsp_type       rsp_ff;

   logic          issue;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [63:0]   wr_data;
   logic [CW-1:0] last_w;
   logic [LW-1:0] count_ext;
   logic [LW-1:0] cap_ext;
   logic [LW-1:0] limit;

   // search issues one read per cycle while entries remain
   assign issue   = cmd.search && (rd_idx_ff < count_ff);
   assign last_w  = count_ff - CW'(1);
   assign rd_en   = issue || cmd.rd_last;
   assign rd_addr = cmd.rd_last ? last_w[AW-1:0] : rd_idx_ff[AW-1:0];

   // single write port: append at the end or fill the removed slot
   assign wr_en   = cmd.append || cmd.move;
   assign wr_addr = cmd.append ? count_ff[AW-1:0] : slot_ff;
   assign wr_data = cmd.append ? key_ff : rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // effective limit is the smaller of capacity and depth
   assign count_ext = LW'(count_ff);
   assign cap_ext   = LW'(cap);
   assign limit     = (cap_ext > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : cap_ext;

   assign stat.found     = cmp_vld_ff && (rdata_ff == key_ff);
   assign stat.done      = !cmp_vld_ff && (rd_idx_ff == count_ff);
   assign stat.is_remove = (op_ff == OP_REMOVE);
   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ext >= limit);

   // search pointer and compare pipeline
   always_comb begin
      rd_idx_in  = rd_idx_ff;
      cmp_vld_in = cmp_vld_ff;
      if (cmd.load) begin
         rd_idx_in  = '0;
         cmp_vld_in = 1'b0;
      end else if (cmd.search) begin
         rd_idx_in  = issue ? rd_idx_ff + CW'(1) : rd_idx_ff;
         cmp_vld_in = issue;
      end
   end

   // entry count
   always_comb begin
      count_in = count_ff;
      if (cmd.append) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.move) begin
         count_in = last_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         rd_idx_ff  <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         rd_idx_ff  <= rd_idx_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   // key, compare index, hit slot and result payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= {req_payload.real_part, req_payload.imag_part};
         op_ff  <= req_payload.opcode;
      end
      if (issue) begin
         cmp_idx_ff <= rd_idx_ff[AW-1:0];
      end
      if (cmd.search && stat.found) begin
         slot_ff <= cmp_idx_ff;
      end
      if (cmd.rsp_load) begin
         rsp_ff.status      <= cmd.rsp_status;
         rsp_ff.entry_count <= count_ext[4:0];
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// ----- rtl/core/complex_pair_set_table.sv -----
// ----------------------------------------------------------------------------
// complex_pair_set_table
// Set of distinct signed complex pairs with linear search and swap-remove.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one beat per operation, opcode 0 adds and 1 removes the pair
//   (real_part, imag_part). Handshake is valid/stall, taken when valid is
//   high and stall low. One operation is handled at a time.
//   rsp channel: exactly one beat per operation, carrying a status code and
//   the entry count after the operation.
//   csr port: APB-style, register 0 (byte address 0) is capacity_in_use,
//   5 bits, reset 16; values above TABLE_DEPTH act as TABLE_DEPTH.
// Timing: an add or a remove searches the stored entries in order; a remove
//   that hits then reads the last entry and moves it into the hit slot. The
//   search reads one entry per cycle from the entry memory, and the next beat
//   is taken in the idle state after the result is loaded.
// Reset: the set is emptied (count zero) and capacity returns to 16; the
//   entry memory is not cleared since only used entries are ever read.
// Stall: the result sits in an output register; a new beat may be taken
//   while it waits, but the next result is held until the old one is taken.
// ----------------------------------------------------------------------------
module complex_pair_set_table
   import cpst_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = DEPTH_DEFAULT
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_payload,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   logic [4:0] cap_ff;
   logic       cap_sel;
   logic       cap_wr;
   cmd_type    cmd;
   stat_type   stat;

   // capacity register, word 0
   assign csr_pready = 1'b1;
   assign cap_sel    = (csr_paddr[2] == 1'b0);
   assign cap_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && cap_sel;
   assign csr_prdata = cap_sel ? CSR_DW'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (cap_wr) begin
         cap_ff <= csr_pwdata[4:0];
      end
   end

   cpst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   cpst_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cap         (cap_ff),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- rtl/core/cpst_checker.sv -----
// ----------------------------------------------------------------------------
// cpst_checker
// Port-level checks on the complex pair set table, bound to the top level.
// ----------------------------------------------------------------------------
module cpst_checker
   import cpst_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   // status is always a defined code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status <= ST_EMPTY))
      else $error("undefined status code");

   // one operation at a time: input closes right after a beat is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second beat accepted while busy");

   // a successful add leaves at least one entry
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == ST_ADDED) |-> (rsp_payload.entry_count != 5'd0))
      else $error("add reported with empty table");

endmodule

bind complex_pair_set_table cpst_checker u_cpst_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// ----- sim/tb_complex_pair_set_table.sv -----
// ----------------------------------------------------------------------------
// tb_complex_pair_set_table
// Self-checking bench for the complex pair set table: a directed script of
// adds and removes walks the edge cases (empty set, refused adds, one-bit
// near matches, capacity above and below the entry count), then random
// add/remove beats drawn from a small pair pool run under several capacity
// settings and idling mixes. Every accepted request is run through a local
// model of the set; results are matched in order to it or to typed values.
// ----------------------------------------------------------------------------
module tb_complex_pair_set_table;
   import cpst_pkg::*;

   localparam int unsigned DEPTH          = DEPTH_DEFAULT;
   localparam int unsigned CLK_PERIOD     = 8;
   localparam int unsigned RESET_CYCLES   = 9;
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned LONG_HOLD      = 300;
   localparam int unsigned TAIL_CYCLES    = 40;
   localparam int unsigned MAX_REPORTS    = 10;
   localparam int unsigned POOL_SIZE      = 20;
   localparam int unsigned PHASE_ITEMS    = 50;
   localparam int unsigned SCRIPT_LEN     = 29;
   localparam logic [CSR_AW-1:0] CAP_ADDR = '0;
   localparam logic ROW_BEAT = 1'b0;
   localparam logic ROW_CSR  = 1'b1;

   // one line of the directed script: a capacity write or a request beat
   typedef struct packed {
      logic        kind;
      logic [4:0]  cap;
      logic        opcode;
      logic [31:0] re;
      logic [31:0] im;
      logic        fixed;
      logic [2:0]  status;
      logic [4:0]  count;
   } script_row_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   req_type           req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   rsp_type           rsp_payload;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // typed-in expectation travelling alongside the current request beat
   logic    beat_fixed = 1'b0;
   rsp_type beat_rsp   = '0;

   // model of the set
   logic [31:0] set_real [DEPTH];
   logic [31:0] set_imag [DEPTH];
   int unsigned set_count = 0;
   logic [4:0]  cap_shadow = CAP_RESET;

   rsp_type     expected_rsp_q [$];
   int unsigned err_count  = 0;
   int unsigned idle_ticks = 0;

   // idling controls and the long receiver hold-off
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   bit          hold_req   = 1'b0;
   bit          hold_taken = 1'b0;
   int unsigned hold_left  = 0;

   // pair pool for random beats
   logic [31:0] pool_re [POOL_SIZE];
   logic [31:0] pool_im [POOL_SIZE];

   script_row_type script [SCRIPT_LEN];

   complex_pair_set_table #(.TABLE_DEPTH(DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // apply one add or remove to the model set and return the result beat
   function automatic rsp_type apply_pair_op(req_type op);
      rsp_type     r;
      int unsigned lim;
      int          slot;
      int unsigned k;
      lim  = (cap_shadow > DEPTH) ? DEPTH : cap_shadow;
      slot = -1;
      for (k = 0; k < set_count; k++) begin
         if (slot < 0 && set_real[k] == op.real_part && set_imag[k] == op.imag_part)
            slot = k;
      end
      if (op.opcode == OP_ADD) begin
         if (slot >= 0) begin
            r.status = ST_PRESENT;
         end else if (set_count >= lim) begin
            r.status = ST_FULL;
         end else begin
            set_real[set_count] = op.real_part;
            set_imag[set_count] = op.imag_part;
            set_count++;
            r.status = ST_ADDED;
         end
      end else if (set_count == 0) begin
         r.status = ST_EMPTY;
      end else if (slot >= 0) begin
         // swap-remove: last used entry fills the hole
         set_real[slot] = set_real[set_count - 1];
         set_imag[slot] = set_imag[set_count - 1];
         set_count--;
         r.status = ST_REMOVED;
      end else begin
         r.status = ST_MISSING;
      end
      r.entry_count = set_count[4:0];
      return r;
   endfunction

   function automatic script_row_type op_row(logic op, logic [31:0] re, logic [31:0] im);
      return '{ROW_BEAT, 5'd0, op, re, im, 1'b0, 3'd0, 5'd0};
   endfunction

   function automatic script_row_type op_row_fixed(logic op, logic [31:0] re,
                                                   logic [31:0] im,
                                                   logic [2:0] st, logic [4:0] cnt);
      return '{ROW_BEAT, 5'd0, op, re, im, 1'b1, st, cnt};
   endfunction

   function automatic script_row_type cap_row(logic [4:0] value);
      return '{ROW_CSR, value, OP_ADD, 32'h0, 32'h0, 1'b0, 3'd0, 5'd0};
   endfunction

   // half random words, half the sign and zero corners
   function automatic logic [31:0] corner_word();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic void refresh_pool();
      int unsigned i;
      for (i = 0; i < POOL_SIZE; i++) begin
         pool_re[i] = corner_word();
         pool_im[i] = corner_word();
      end
   endfunction

   // pool pairs mostly, plus fresh pairs and one-bit near misses
   function automatic req_type pick_pair_op(int unsigned add_pct);
      req_type     it;
      int unsigned idx;
      int unsigned sel;
      it.opcode    = ($urandom_range(99) < add_pct) ? OP_ADD : OP_REMOVE;
      idx          = $urandom_range(POOL_SIZE - 1);
      sel          = $urandom_range(99);
      it.real_part = pool_re[idx];
      it.imag_part = pool_im[idx];
      if (sel < 8) begin
         it.real_part = corner_word();
         it.imag_part = corner_word();
      end else if (sel < 14) begin
         if ($urandom_range(1) == 0)
            it.real_part[$urandom_range(31)] ^= 1'b1;
         else
            it.imag_part[$urandom_range(31)] ^= 1'b1;
      end
      return it;
   endfunction

   function automatic void flag_error(string msg);
      err_count++;
      if (err_count <= MAX_REPORTS)
         $display("mismatch at %0t: %s", $time, msg);
   endfunction

   // offer one beat, with random idle cycles ahead of it
   task automatic send_pair_op(req_type item, logic fixed, rsp_type fixed_rsp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      beat_fixed  <= fixed;
      beat_rsp    <= fixed_rsp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop offering and wait until every result is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_rsp_q.size() != 0);
      @(posedge clock);
   endtask

   task automatic write_capacity(logic [4:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CAP_ADDR;
      csr_pwdata  <= {{(CSR_DW - 5){1'b0}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      cap_shadow = value;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // receiver: random stall, or one long hold-off when asked
   always @(posedge clock) begin
      if (hold_req && !hold_taken) begin
         hold_left  = LONG_HOLD;
         hold_taken = 1'b1;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // monitor: check result beats, predict accepted requests, watchdog
   always @(posedge clock) begin : monitor
      rsp_type want;
      rsp_type got;
      bit      took;
      if (!reset) begin
         took = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            took = 1'b1;
            if (expected_rsp_q.size() == 0) begin
               flag_error($sformatf("result beat with nothing expected (status %0d count %0d)",
                                    rsp_payload.status, rsp_payload.entry_count));
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_payload.status !== want.status)
                  flag_error($sformatf("status expected %0d got %0d",
                                       want.status, rsp_payload.status));
               if (rsp_payload.entry_count !== want.entry_count)
                  flag_error($sformatf("entry_count expected %0d got %0d",
                                       want.entry_count, rsp_payload.entry_count));
            end
         end
         if (req_valid && !req_stall) begin
            took = 1'b1;
            got  = apply_pair_op(req_payload);
            expected_rsp_q.push_back(beat_fixed ? beat_rsp : got);
         end
         idle_ticks = took ? 0 : idle_ticks + 1;
         if (idle_ticks >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [4:0]  cap_plan [12];
      int unsigned row;
      int unsigned pace;
      int unsigned ph;
      int unsigned n;
      int unsigned add_pct;
      req_type     item;
      rsp_type     fixed_rsp;

      // directed script: empty set, extremes, near matches, refused adds
      script = '{
         op_row_fixed(OP_REMOVE, 32'h0000_0000, 32'h0000_0000, ST_EMPTY, 5'd0),
         op_row_fixed(OP_ADD,    32'h8000_0000, 32'h7fff_ffff, ST_ADDED, 5'd1),
         op_row_fixed(OP_ADD,    32'h8000_0000, 32'h7fff_ffff, ST_PRESENT, 5'd1),
         op_row_fixed(OP_ADD,    32'h7fff_ffff, 32'h8000_0000, ST_ADDED, 5'd2),
         op_row      (OP_ADD,    32'h8000_0000, 32'h7fff_fffe),
         op_row      (OP_ADD,    32'h8000_0001, 32'h7fff_ffff),
         op_row      (OP_ADD,    32'h0000_0000, 32'h0000_0000),
         op_row      (OP_ADD,    32'hffff_ffff, 32'hffff_ffff),
         op_row_fixed(OP_REMOVE, 32'h0000_0001, 32'h0000_0000, ST_MISSING, 5'd6),
         op_row      (OP_REMOVE, 32'h8000_0000, 32'h7fff_ffff),
         op_row      (OP_REMOVE, 32'h8000_0000, 32'h7fff_ffff),
         op_row      (OP_REMOVE, 32'h0000_0000, 32'h0000_0000),
         cap_row(5'd2),
         op_row_fixed(OP_ADD,    32'h0000_0005, 32'h0000_0005, ST_FULL, 5'd4),
         op_row_fixed(OP_ADD,    32'hffff_ffff, 32'hffff_ffff, ST_PRESENT, 5'd4),
         op_row      (OP_REMOVE, 32'h7fff_ffff, 32'h8000_0000),
         cap_row(5'd0),
         op_row_fixed(OP_ADD,    32'h0000_0000, 32'h0000_0000, ST_FULL, 5'd3),
         op_row      (OP_REMOVE, 32'hffff_ffff, 32'hffff_ffff),
         op_row      (OP_REMOVE, 32'h8000_0000, 32'h7fff_fffe),
         op_row      (OP_REMOVE, 32'h8000_0001, 32'h7fff_ffff),
         op_row_fixed(OP_REMOVE, 32'h8000_0001, 32'h7fff_ffff, ST_EMPTY, 5'd0),
         cap_row(5'd31),
         op_row      (OP_ADD,    32'h0000_0000, 32'h0000_0000),
         op_row      (OP_ADD,    32'h5555_5555, 32'haaaa_aaaa),
         cap_row(5'd1),
         op_row_fixed(OP_ADD,    32'h0000_0001, 32'h0000_0001, ST_FULL, 5'd2),
         op_row_fixed(OP_ADD,    32'h0000_0000, 32'h0000_0000, ST_PRESENT, 5'd2),
         op_row      (OP_REMOVE, 32'h0000_0000, 32'h0000_0000)
      };

      // capacity per random phase, extremes included
      cap_plan = '{5'd16, 5'd31, 5'd3, 5'd0, 5'd17, 5'd8, 5'd1, 5'd16,
                   5'd5, 5'd31, 5'd0, 5'd0};
      cap_plan[11] = 5'($urandom_range(31));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct  = 17;
      recv_stall_pct = 49;

      // walk the directed script
      for (row = 0; row < SCRIPT_LEN; row++) begin
         if (script[row].kind == ROW_CSR) begin
            wait_drained();
            write_capacity(script[row].cap);
         end else begin
            item.opcode          = script[row].opcode;
            item.real_part       = script[row].re;
            item.imag_part       = script[row].im;
            fixed_rsp.status      = script[row].status;
            fixed_rsp.entry_count = script[row].count;
            send_pair_op(item, script[row].fixed, fixed_rsp);
         end
      end

      // random phases under three idling mixes
      for (pace = 0; pace < 3; pace++) begin
         case (pace)
            0: begin send_idle_pct = 17; recv_stall_pct = 49; end
            1: begin send_idle_pct = 49; recv_stall_pct = 17; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         for (ph = 0; ph < 4; ph++) begin
            wait_drained();
            write_capacity(cap_plan[pace * 4 + ph]);
            refresh_pool();
            add_pct = (ph % 2 == 0) ? 75 : 35;
            // long receiver hold-off while beats keep coming
            if (pace == 2 && ph == 0)
               hold_req = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
               send_pair_op(pick_pair_op(add_pct), 1'b0, '0);
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/cpst_pkg.sv
rtl/core/cpst_ctrl.sv
rtl/core/cpst_dp.sv
rtl/core/complex_pair_set_table.sv
rtl/core/cpst_checker.sv
sim/tb_complex_pair_set_table.sv
